// ----- hdl/abse_pkg.sv -----
// ----------------------------------------------------------------------------
// abse_pkg
// Shared types, shift codes and the ASCII to US-TTY Baudot lookup.
// ----------------------------------------------------------------------------
package abse_pkg;

  localparam logic [4:0] CODE_LTRS = 5'h1F;
  localparam logic [4:0] CODE_FIGS = 5'h1B;

  // Buffered input word: one character byte or an idle event.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       idle_tick;
  } abse_item_t;

  // Lookup result: hit, which row it came from, and the 5-bit code.
  typedef struct packed {
    logic       hit;
    logic       figs;
    logic [4:0] code;
  } abse_lookup_t;

  // CR, LF and space appear only in the letters row, so they land in letters.
  function automatic abse_lookup_t abse_lookup(input logic [7:0] ch);
    logic [7:0]   up;
    abse_lookup_t r;
    up = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      up = ch - 8'h20;
    end
    r.hit  = 1'b1;
    r.figs = 1'b0;
    r.code = 5'd0;
    unique case (up)
      // letters row
      8'h45: r.code = 5'd1;   // E
      8'h0A: r.code = 5'd2;   // LF
      8'h41: r.code = 5'd3;   // A
      8'h20: r.code = 5'd4;   // space
      8'h53: r.code = 5'd5;   // S
      8'h49: r.code = 5'd6;   // I
      8'h55: r.code = 5'd7;   // U
      8'h0D: r.code = 5'd8;   // CR
      8'h44: r.code = 5'd9;   // D
      8'h52: r.code = 5'd10;  // R
      8'h4A: r.code = 5'd11;  // J
      8'h4E: r.code = 5'd12;  // N
      8'h46: r.code = 5'd13;  // F
      8'h43: r.code = 5'd14;  // C
      8'h4B: r.code = 5'd15;  // K
      8'h54: r.code = 5'd16;  // T
      8'h5A: r.code = 5'd17;  // Z
      8'h4C: r.code = 5'd18;  // L
      8'h57: r.code = 5'd19;  // W
      8'h48: r.code = 5'd20;  // H
      8'h59: r.code = 5'd21;  // Y
      8'h50: r.code = 5'd22;  // P
      8'h51: r.code = 5'd23;  // Q
      8'h4F: r.code = 5'd24;  // O
      8'h42: r.code = 5'd25;  // B
      8'h47: r.code = 5'd26;  // G
      8'h4D: r.code = 5'd28;  // M
      8'h58: r.code = 5'd29;  // X
      8'h56: r.code = 5'd30;  // V
      // figures row
      8'h33: begin r.figs = 1'b1; r.code = 5'd1;  end  // 3
      8'h2D: begin r.figs = 1'b1; r.code = 5'd3;  end  // -
      8'h07: begin r.figs = 1'b1; r.code = 5'd5;  end  // BEL
      8'h38: begin r.figs = 1'b1; r.code = 5'd6;  end  // 8
      8'h37: begin r.figs = 1'b1; r.code = 5'd7;  end  // 7
      8'h24: begin r.figs = 1'b1; r.code = 5'd9;  end  // $
      8'h34: begin r.figs = 1'b1; r.code = 5'd10; end  // 4
      8'h27: begin r.figs = 1'b1; r.code = 5'd11; end  // apostrophe
      8'h2C: begin r.figs = 1'b1; r.code = 5'd12; end  // comma
      8'h21: begin r.figs = 1'b1; r.code = 5'd13; end  // !
      8'h3A: begin r.figs = 1'b1; r.code = 5'd14; end  // :
      8'h28: begin r.figs = 1'b1; r.code = 5'd15; end  // (
      8'h35: begin r.figs = 1'b1; r.code = 5'd16; end  // 5
      8'h22: begin r.figs = 1'b1; r.code = 5'd17; end  // double quote
      8'h29: begin r.figs = 1'b1; r.code = 5'd18; end  // )
      8'h32: begin r.figs = 1'b1; r.code = 5'd19; end  // 2
      8'h23: begin r.figs = 1'b1; r.code = 5'd20; end  // #
      8'h36: begin r.figs = 1'b1; r.code = 5'd21; end  // 6
      8'h30: begin r.figs = 1'b1; r.code = 5'd22; end  // 0
      8'h31: begin r.figs = 1'b1; r.code = 5'd23; end  // 1
      8'h39: begin r.figs = 1'b1; r.code = 5'd24; end  // 9
      8'h3F: begin r.figs = 1'b1; r.code = 5'd25; end  // ?
      8'h26: begin r.figs = 1'b1; r.code = 5'd26; end  // &
      8'h2E: begin r.figs = 1'b1; r.code = 5'd28; end  // .
      8'h2F: begin r.figs = 1'b1; r.code = 5'd29; end  // /
      8'h3B: begin r.figs = 1'b1; r.code = 5'd30; end  // ;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/ascii_to_baudot_shift_encoder.sv -----
// Path: an accepted word passes the input register, then the output register,
// before its first code shows. Throughput: one input word per cycle when no
// shift is needed and out_ready stays high; a word that needs a shift sends
// the shift code and then the character from the output register pair.
// Reset (rst, synchronous): letters shift, input and output registers empty.
// ----------------------------------------------------------------------------
// ascii_to_baudot_shift_encoder
// ASCII to 5-bit US-TTY Baudot with letters/figures shift tracking.
// ----------------------------------------------------------------------------
module ascii_to_baudot_shift_encoder
  import abse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       idle_tick,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] baudot_code,
  output logic       last_code
);

  // Word flow:
  //   input register -> lookup + shift compare -> output register pair
  // The output side holds a head code and an optional queued character.
  // A word that needs a shift loads both; the head is LTRS or FIGS with
  // last_code low, the character follows on the next transfer.
  // Unmapped bytes leave the input register without loading anything
  // and without changing the shift state.

  abse_item_t item;
  logic       held;
  logic       take;

  abse_input_reg u_input_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_byte (char_byte),
    .idle_tick (idle_tick),
    .take      (take),
    .held      (held),
    .item      (item)
  );

  abse_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .held        (held),
    .item        (item),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .baudot_code (baudot_code),
    .last_code   (last_code)
  );

endmodule

// ----- hdl/abse_input_reg.sv -----
// ----------------------------------------------------------------------------
// abse_input_reg
// Input register: holds one accepted word until the emitter takes it.
// ----------------------------------------------------------------------------
module abse_input_reg
  import abse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       idle_tick,
  input  logic       take,
  output logic       held,
  output abse_item_t item
);

  // refill in the same cycle the held word leaves
  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.char_byte <= char_byte;
      item.idle_tick <= idle_tick;
    end
  end

endmodule

// ----- hdl/abse_emitter.sv -----
// ----------------------------------------------------------------------------
// abse_emitter
// Shift tracking and output register; queues an optional shift code
// ahead of the character code.
// ----------------------------------------------------------------------------
module abse_emitter
  import abse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       held,
  input  abse_item_t item,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] baudot_code,
  output logic       last_code
);

  abse_lookup_t lk;
  logic         emits;
  logic         shift;
  logic         figs_after;
  logic [4:0]   char_code;
  logic         free;
  logic         load;

  logic         figures_mode;
  logic         head_valid;   // word on the output
  logic         tail_valid;   // character queued behind a shift code
  logic [4:0]   head_code;
  logic [4:0]   tail_code;

  always_comb begin
    lk = abse_lookup(item.char_byte);
    if (item.idle_tick) begin
      emits      = 1'b1;
      shift      = 1'b0;
      figs_after = 1'b0;
      char_code  = CODE_LTRS;
    end else begin
      emits      = lk.hit;
      shift      = lk.hit && (lk.figs != figures_mode);
      figs_after = lk.hit ? lk.figs : figures_mode;
      char_code  = lk.code;
    end
  end

  assign free = !head_valid || (out_ready && !tail_valid);
  // unmapped bytes drop without touching the output side
  assign take = held && (!emits || free);
  assign load = take && emits;

  assign out_valid   = head_valid;
  assign baudot_code = head_code;
  assign last_code   = !tail_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      figures_mode <= 1'b0;
      head_valid   <= 1'b0;
      tail_valid   <= 1'b0;
    end else begin
      if (take) begin
        figures_mode <= figs_after;
      end
      if (load) begin
        head_valid <= 1'b1;
        tail_valid <= shift;
      end else if (head_valid && out_ready) begin
        if (tail_valid) begin
          tail_valid <= 1'b0;
        end else begin
          head_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head_code <= shift ? (figs_after ? CODE_FIGS : CODE_LTRS) : char_code;
      tail_code <= char_code;
    end else if (head_valid && out_ready && tail_valid) begin
      head_code <= tail_code;
    end
  end

`ifndef ASSERT_OFF
  a_lead_is_shift: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_code |-> baudot_code == CODE_LTRS || baudot_code == CODE_FIGS)
    else $error("non-final word is not a shift code");

  a_tail_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_code |=> out_valid && last_code)
    else $error("character did not follow its shift code");

  a_idle_unshifts: assert property (@(posedge clk) disable iff (rst)
    load && item.idle_tick |=> !figures_mode)
    else $error("idle did not select letters");

  // the idle LTRS word is itself the unshift
  a_shift_needs_load: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && figures_mode != $past(figures_mode) |->
      $past(load) && ($past(shift) || $past(item.idle_tick)))
    else $error("shift state changed without a shift code");
`endif

endmodule
